@@ rtl/pss_pkg.sv @@
package pss_pkg;

  // Sizing of the stores.
  localparam int MAX_LEN    = 64;
  localparam int MASS_BITS  = 14;
  localparam int COUNT_BITS = 12;

  // Fixed field widths.
  localparam int EXP_BITS   = 14;
  localparam int RES_BITS   = 8;
  localparam int SCORE_BITS = 12;
  localparam int LMASS_BITS = 8;

  // Derived sizes.
  localparam int HIST_SIZE = 2 ** MASS_BITS;
  localparam int CNT_BITS  = $clog2(MAX_LEN + 1);
  localparam int IDX_BITS  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_ADD_MASS = 2'd1,
    CMD_ADD_RES  = 2'd2,
    CMD_FINISH   = 2'd3
  } cmd_t;

  // Integer residue mass of an amino-acid letter; unknown letters weigh zero.
  function automatic logic [LMASS_BITS-1:0] letter_mass(input logic [RES_BITS-1:0] ch);
    logic [LMASS_BITS-1:0] m;
    case (ch)
      "G": m = 8'd57;
      "A": m = 8'd71;
      "S": m = 8'd87;
      "P": m = 8'd97;
      "V": m = 8'd99;
      "T": m = 8'd101;
      "C": m = 8'd103;
      "I": m = 8'd113;
      "L": m = 8'd113;
      "N": m = 8'd114;
      "D": m = 8'd115;
      "K": m = 8'd128;
      "Q": m = 8'd128;
      "E": m = 8'd129;
      "M": m = 8'd131;
      "H": m = 8'd137;
      "F": m = 8'd147;
      "R": m = 8'd156;
      "Y": m = 8'd163;
      "W": m = 8'd186;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/peptide_spectrum_score_core.sv @@
// Add mass: busy stays low, the next word is taken in the following cycle.
// Add residue: busy while the n residues held before it are walked; one histogram
//   read-modify-write per cycle through a registered-read memory with write forwarding.
// Finish: the word moves the core to ST_FIN, which registers done as a pulse; the receiver cannot stall.
// Reset and the clear command sweep the 16384-entry histogram, one entry a cycle,
//   and busy stays high until the sweep has ended.
module peptide_spectrum_score_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          command,
  input  logic [pss_pkg::RES_BITS-1:0]        residue,
  input  logic [pss_pkg::EXP_BITS-1:0]        exp_mass,
  output logic                                done,
  output logic [pss_pkg::SCORE_BITS-1:0]      match_score,
  output logic                                overflow
);
  import pss_pkg::*;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RES, ST_FIN} state_t;

  state_t                 state;
  logic [MASS_BITS-1:0]   clr_addr;
  logic [CNT_BITS-1:0]    count;
  logic [CNT_BITS-1:0]    lim;
  logic [CNT_BITS-1:0]    idx;
  logic [MASS_BITS-1:0]   running_mass;
  logic [SCORE_BITS-1:0]  score;
  logic [SCORE_BITS-1:0]  score_next;
  logic                   ovf_flag;
  logic                   pf_valid;

  // Histogram pipeline: request stage, update stage, last-write forwarding register.
  logic                   p1_valid;
  logic [MASS_BITS-1:0]   p1_addr;
  logic                   p1_inc;
  logic                   p2_valid;
  logic [MASS_BITS-1:0]   p2_addr;
  logic                   p2_inc;
  logic                   wr_valid;
  logic [MASS_BITS-1:0]   wr_addr;
  logic [COUNT_BITS-1:0]  wr_data;
  logic [COUNT_BITS-1:0]  hist_q;
  logic [COUNT_BITS-1:0]  hist_cur;
  logic [COUNT_BITS-1:0]  hist_new;

  logic [COUNT_BITS-1:0]  hist_mem [HIST_SIZE];
  logic [MASS_BITS-1:0]   pref_mem [MAX_LEN];
  logic [MASS_BITS-1:0]   pref_q;

  logic                   acc;
  cmd_t                   cmd;
  logic [MASS_BITS:0]     total;
  logic                   res_ok;
  logic                   em_ok;

  assign busy = (state != ST_IDLE);
  assign acc  = start && !busy;
  assign cmd  = cmd_t'(command);

  // New prefix mass and the checks on length and mass range.
  assign total  = {1'b0, running_mass} + (MASS_BITS + 1)'(letter_mass(residue));
  assign res_ok = (count < CNT_BITS'(MAX_LEN)) && !total[MASS_BITS];
  assign em_ok  = (32'(exp_mass) < HIST_SIZE);

  // Histogram requests: one from the accepted word, or one per stored prefix.
  always_comb begin
    p1_valid = 1'b0;
    p1_addr  = '0;
    p1_inc   = 1'b0;
    if (state == ST_IDLE && acc) begin
      unique case (cmd)
        CMD_ADD_MASS: begin
          p1_valid = em_ok;
          p1_addr  = MASS_BITS'(exp_mass);
          p1_inc   = 1'b1;
        end
        CMD_ADD_RES: begin
          p1_valid = res_ok;
          p1_addr  = total[MASS_BITS-1:0];
        end
        CMD_FINISH: begin
          p1_valid = 1'b1;
        end
        CMD_CLEAR: begin
          p1_valid = 1'b0;
        end
      endcase
    end else if (state == ST_RES && pf_valid) begin
      p1_valid = 1'b1;
      p1_addr  = running_mass - pref_q;
    end
  end

  // Update stage: forward the write of the previous cycle, then count up or consume.
  always_comb begin
    hist_cur   = (wr_valid && wr_addr == p2_addr) ? wr_data : hist_q;
    hist_new   = hist_cur;
    score_next = score;
    if (p2_inc) begin
      if (hist_cur != '1) hist_new = hist_cur + 1'b1;
    end else if (hist_cur != '0) begin
      hist_new = hist_cur - 1'b1;
      if (p2_valid && score != '1) score_next = score + 1'b1;
    end
  end

  // Histogram memory: clearing sweep or update write, registered read.
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      hist_mem[clr_addr] <= '0;
    end else if (p2_valid) begin
      hist_mem[p2_addr] <= hist_new;
    end
    hist_q <= hist_mem[p1_addr];
  end

  // Prefix memory: written when a residue is taken, read one entry a cycle.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && acc && cmd == CMD_ADD_RES && res_ok) begin
      pref_mem[count[IDX_BITS-1:0]] <= total[MASS_BITS-1:0];
    end
    pref_q <= pref_mem[idx[IDX_BITS-1:0]];
  end

  // Control sequence and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      count        <= '0;
      lim          <= '0;
      idx          <= '0;
      running_mass <= '0;
      score        <= '0;
      ovf_flag     <= 1'b0;
      pf_valid     <= 1'b0;
      p2_valid     <= 1'b0;
      wr_valid     <= 1'b0;
      done         <= 1'b0;
      match_score  <= '0;
      overflow     <= 1'b0;
    end else begin
      done     <= 1'b0;
      pf_valid <= 1'b0;
      p2_valid <= p1_valid;
      p2_addr  <= p1_addr;
      p2_inc   <= p1_inc;
      wr_valid <= p2_valid;
      wr_addr  <= p2_addr;
      wr_data  <= hist_new;
      score    <= score_next;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (acc) begin
            unique case (cmd)
              CMD_CLEAR: begin
                state        <= ST_CLEAR;
                clr_addr     <= '0;
                count        <= '0;
                running_mass <= '0;
                score        <= '0;
                ovf_flag     <= 1'b0;
              end
              CMD_ADD_MASS: begin
                state <= ST_IDLE;
              end
              CMD_ADD_RES: begin
                if (res_ok) begin
                  running_mass <= total[MASS_BITS-1:0];
                  count        <= count + 1'b1;
                  lim          <= count;
                  idx          <= '0;
                  state        <= ST_RES;
                end else begin
                  ovf_flag <= 1'b1;
                end
              end
              CMD_FINISH: begin
                state <= ST_FIN;
              end
            endcase
          end
        end
        ST_RES: begin
          // Walk the earlier prefixes, then let the last update retire.
          if (idx < lim) begin
            idx      <= idx + 1'b1;
            pf_valid <= 1'b1;
          end else if (!pf_valid) begin
            state <= ST_IDLE;
          end
        end
        ST_FIN: begin
          done        <= 1'b1;
          match_score <= score_next;
          overflow    <= ovf_flag;
          state       <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
